@@ rtl/sha_pkg.sv @@
package sha_pkg;

   localparam int WordWidth = 32;
   localparam int QueueDepth = 4;
   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 40;

   // one classified entry handed from front to back
   typedef struct packed {
      logic       has_data;
      logic [7:0] data_byte;
      logic       end_of_message;
   } item_type;

   typedef logic [WordWidth-1:0] word_type;

   function automatic word_type round_const(input logic [5:0] idx);
      word_type k [0:63];
      k = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[idx];
   endfunction

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type h [0:7];
      h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[idx];
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ rtl/sha_queue.sv @@
module sha_queue #(
   parameter int Depth = sha_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  sha_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output sha_pkg::item_type pop_item
);
   import sha_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   item_type              slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != (PtrWidth+1)'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/sha_core.sv @@
module sha_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   output logic                             item_ready,
   input  sha_pkg::item_type                item,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sha_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic                             rsp_tlast
);
   import sha_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_ROUND  = 7'b0000010,
      ST_ADD    = 7'b0000100,
      ST_PAD    = 7'b0001000,
      ST_LENGTH = 7'b0010000,
      ST_EMIT   = 7'b0100000,
      ST_ZERO   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   word_type    hash_ff [8];
   word_type    hash_in [8];
   word_type    work_ff [8];
   word_type    work_in [8];
   word_type    sched_ff [16];
   word_type    sched_in [16];
   logic [63:0] bit_len_ff, bit_len_in;
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  emit_ff, emit_in;
   // set while the block in flight is the final one of a message
   logic        final_ff, final_in;
   // set when padding spilled past the length field and a second block follows
   logic        spill_ff, spill_in;
   // true from a full-block compress on an end item until its padding block is started
   logic        pad_pending_ff, pad_pending_in;
   logic        out_valid_ff, out_valid_in;
   logic [RspDataWidth-1:0] out_data_ff, out_data_in;
   logic        out_last_ff, out_last_in;

   word_type    wt, s0, s1, t1, t2, e, a;
   logic [3:0]  ridx;
   logic [3:0]  widx;
   logic [1:0]  lane;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign item_ready = (state_ff == ST_IDLE);

   assign ridx = round_ff[3:0];
   assign widx = fill_ff[5:2];
   assign lane = fill_ff[1:0];

   always_comb begin
      e  = work_ff[4];
      a  = work_ff[0];
      s1 = rotr(sched_ff[ridx - 4'd2], 17) ^ rotr(sched_ff[ridx - 4'd2], 19)
         ^ (sched_ff[ridx - 4'd2] >> 10);
      s0 = rotr(sched_ff[ridx - 4'd15], 7) ^ rotr(sched_ff[ridx - 4'd15], 18)
         ^ (sched_ff[ridx - 4'd15] >> 3);
      wt = (round_ff < 6'd16) ? sched_ff[ridx]
         : s1 + sched_ff[ridx - 4'd7] + s0 + sched_ff[ridx];
      t1 = work_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & work_ff[5]) ^ (~e & work_ff[6])) + round_const(round_ff) + wt;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & work_ff[1]) ^ (a & work_ff[2]) ^ (work_ff[1] & work_ff[2]));
   end

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      work_in      = work_ff;
      sched_in     = sched_ff;
      bit_len_in   = bit_len_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      emit_in      = emit_ff;
      final_in     = final_ff;
      spill_in     = spill_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               final_in = item.end_of_message;
               if (item.has_data) begin
                  if (lane == 2'd0) begin
                     sched_in[widx] = {item.data_byte, 24'd0};
                  end else begin
                     sched_in[widx] = sched_ff[widx]
                        | (word_type'(item.data_byte) << (5'd8 * (5'd3 - 5'(lane))));
                  end
                  bit_len_in = bit_len_ff + 64'd8;
                  fill_in    = fill_ff + 6'd1;
               end
               if (item.has_data && fill_ff == 6'd63) begin
                  work_in  = hash_ff;
                  round_in = '0;
                  spill_in = 1'b0;
                  state_in = ST_ROUND;
               end else if (item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // drop in the marker byte and clear the rest of the block
            for (int w = 0; w < 16; w++) begin
               if (4'(w) > widx) begin
                  sched_in[w] = '0;
               end
            end
            unique case (lane)
               2'd0: sched_in[widx] = 32'h8000_0000;
               2'd1: sched_in[widx] = {sched_ff[widx][31:24], 24'h800000};
               2'd2: sched_in[widx] = {sched_ff[widx][31:16], 16'h8000};
               default: sched_in[widx] = {sched_ff[widx][31:8], 8'h80};
            endcase
            work_in  = hash_ff;
            round_in = '0;
            if (fill_ff >= 6'd56) begin
               spill_in = 1'b1;
               state_in = ST_ROUND;
            end else begin
               spill_in = 1'b0;
               state_in = ST_LENGTH;
            end
         end
         ST_ZERO: begin
            for (int w = 0; w < 16; w++) begin
               sched_in[w] = '0;
            end
            work_in  = hash_ff;
            round_in = '0;
            spill_in = 1'b0;
            state_in = ST_LENGTH;
         end
         ST_LENGTH: begin
            sched_in[14] = bit_len_ff[63:32];
            sched_in[15] = bit_len_ff[31:0];
            state_in     = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff >= 6'd16) begin
               sched_in[ridx] = wt;
            end
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int w = 0; w < 8; w++) begin
               hash_in[w] = hash_ff[w] + work_ff[w];
            end
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (pad_pending_ff) begin
               // a full block with end set still needs its own padding block
               state_in = ST_PAD;
            end else if (spill_ff) begin
               state_in = ST_ZERO;
            end else begin
               state_in = ST_EMIT;
               emit_in  = '0;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_data_in  = {5'd0, emit_ff, hash_ff[emit_ff]};
               out_last_in  = (emit_ff == 3'd7);
               emit_in      = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  for (int w = 0; w < 8; w++) begin
                     hash_in[w] = init_hash(3'(w));
                  end
                  bit_len_in = '0;
                  fill_in    = '0;
                  final_in   = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pad_pending_in = pad_pending_ff;
      if (state_ff == ST_IDLE && item_valid) begin
         pad_pending_in = item.has_data && fill_ff == 6'd63 && item.end_of_message;
      end else if (state_ff == ST_PAD) begin
         pad_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bit_len_ff     <= '0;
         fill_ff        <= '0;
         round_ff       <= '0;
         emit_ff        <= '0;
         final_ff       <= 1'b0;
         spill_ff       <= 1'b0;
         pad_pending_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         for (int w = 0; w < 8; w++) begin
            hash_ff[w] <= init_hash(3'(w));
            work_ff[w] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         bit_len_ff     <= bit_len_in;
         fill_ff        <= fill_in;
         round_ff       <= round_in;
         emit_ff        <= emit_in;
         final_ff       <= final_in;
         spill_ff       <= spill_in;
         pad_pending_ff <= pad_pending_in;
         out_valid_ff   <= out_valid_in;
         hash_ff        <= hash_in;
         work_ff        <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff    <= sched_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

endmodule

@@ rtl/sha256_message_hasher.sv @@
// channel | direction | tdata (low bit up)                          | tuser / tlast
// req     | in        | [0] has_data, [8:1] data_byte, rest zero    | tlast = end_of_message
// rsp     | out       | [31:0] digest_word, [34:32] word_index, rest 0 | tlast = last_word
//
// A data byte passes through the front queue; every 64th byte starts a
// compression: the round loop, then a fold of the working state into the hash.
// An end word adds padding (one or two blocks, each compressed the same way) and then
// eight digest words, one per cycle while rsp_tready holds high.
// Reset is synchronous and restores the initial hash value; stalls on rsp
// hold the back end while the queue keeps taking words until it is full.
module sha256_message_hasher #(
   parameter int QueueDepth = sha_pkg::QueueDepth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sha_pkg::ReqDataWidth-1:0] req_tdata,  // [0] has_data, [8:1] data_byte
   input  logic                             req_tlast,  // end_of_message
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sha_pkg::RspDataWidth-1:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_index
   output logic                             rsp_tlast   // last_word
);
   import sha_pkg::*;

   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item.has_data       = req_tdata[0];
   assign in_item.data_byte      = req_tdata[8:1];
   assign in_item.end_of_message = req_tlast;

   sha_queue #(.Depth(QueueDepth)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (in_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/sha_checker.sv @@
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last flag off word seven");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid |->
      rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1)
      else $error("word index skipped");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:35] == 5'd0)
      else $error("pad bits set");
endmodule

bind sha256_message_hasher sha_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
